>>> rtl/core/iirdf1_pkg.sv
// Shared constants and types for the direct form I IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  localparam int COEF_BITS       = 16;
  localparam int FRAC_BITS       = 14;
  localparam int NUM_REGS        = 5;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;

  localparam int FF_TAPS_DEF     = 3;
  localparam int FB_TAPS_DEF     = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [COEF_BITS-1:0] COEF_B0_RST = COEF_BITS'(16384);

  // Register index, taken from the word address of the configuration port
  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_bank_t;

endpackage

`default_nettype wire

>>> rtl/core/iirdf1_if.sv
// Valid/ready channel interfaces for the sample input and the filtered output.
`timescale 1ns / 1ps
`default_nettype none

interface iirdf1_in_if #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf1_out_if #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_out;
  logic                   saturated;

  modport source (output valid, output filtered_out, output saturated, input ready);
  modport sink   (input valid, input filtered_out, input saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/core/iirdf1_tap_cell.sv
// One tap of the filter: a history register, its product and a stage of the sum chain.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_tap_cell #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_W       = iirdf1_pkg::COEF_BITS + iirdf1_pkg::SAMPLE_BITS_DEF + 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic [SAMPLE_BITS-1:0]               shift_in,
  input  logic signed [iirdf1_pkg::COEF_BITS-1:0] coef,
  input  logic                                 tok_in,
  input  logic signed [ACC_W-1:0]              psum_in,
  output logic [SAMPLE_BITS-1:0]               sample_q,
  output logic                                 tok_out,
  output logic signed [ACC_W-1:0]              psum_out
);
  import iirdf1_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0]   sample_r, sample_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  psum_r, psum_nxt;
  logic                     tok_r;

  always_comb begin
    sample_nxt = shift_en ? shift_in : sample_r;
    prod_nxt   = coef * $signed(sample_r);
    psum_nxt   = psum_in + $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      tok_r    <= 1'b0;
    end else begin
      sample_r <= sample_nxt;
      tok_r    <= tok_in;
    end
  end

  // Product and partial sum carry no reset; the partial sum holds between tokens
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (tok_in) begin
      psum_r <= psum_nxt;
    end
  end

  assign sample_q = sample_r;
  assign tok_out  = tok_r;
  assign psum_out = psum_r;

endmodule

`default_nettype wire

>>> rtl/core/iirdf1_round_sat.sv
// Round the Q.14 accumulator half up and clamp it to the sample range.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_round_sat #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_W       = iirdf1_pkg::COEF_BITS + iirdf1_pkg::SAMPLE_BITS_DEF + 3
) (
  input  logic signed [ACC_W-1:0] acc,
  output logic [SAMPLE_BITS-1:0]  y,
  output logic                    sat
);
  import iirdf1_pkg::*;

  localparam logic signed [ACC_W:0] MAXV =
    $signed({{(ACC_W-SAMPLE_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W:0] MINV = ~MAXV;
  localparam logic signed [ACC_W:0] HALF = $signed((ACC_W+1)'(1) << (FRAC_BITS-1));

  logic signed [ACC_W:0] biased;
  logic signed [ACC_W:0] rounded;
  logic                  over, under;

  always_comb begin
    biased  = $signed({acc[ACC_W-1], acc}) + HALF;
    rounded = biased >>> FRAC_BITS;
    over    = rounded > MAXV;
    under   = rounded < MINV;
    sat     = over | under;
    if (over) begin
      y = MAXV[SAMPLE_BITS-1:0];
    end else if (under) begin
      y = MINV[SAMPLE_BITS-1:0];
    end else begin
      y = rounded[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iirdf1_cfg_regs.sv
// APB coefficient register bank.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iirdf1_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [iirdf1_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                               pready,
  output iirdf1_pkg::coef_bank_t             coefs
);
  import iirdf1_pkg::*;

  // b0 sits in the lowest slice; every other coefficient resets to zero
  localparam coef_bank_t COEF_RST = {{((NUM_REGS-1)*COEF_BITS){1'b0}}, COEF_B0_RST};

  coef_bank_t coef_r, coef_nxt;
  reg_idx_t   idx;
  logic       hit;
  logic       wr;
  logic [COEF_BITS-1:0] rd_val;

  always_comb begin
    idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    wr     = psel & penable & pwrite;
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: hit = 1'b1;
      default:                                hit = 1'b0;
    endcase
    coef_nxt = coef_r;
    if (wr && hit) begin
      coef_nxt[idx] = pwdata[COEF_BITS-1:0];
    end
    rd_val = hit ? coef_r[idx] : '0;
    prdata = {{(CFG_DATA_W-COEF_BITS){rd_val[COEF_BITS-1]}}, rd_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign pready = 1'b1;
  assign coefs  = coef_r;

endmodule

`default_nettype wire

>>> rtl/core/iir_direct_form_one.sv
// Top level of the direct form I IIR filter.
`timescale 1ns / 1ps
`default_nettype none

// Direct form I IIR filter, y[n] = sum b[k]*x[n-k] + sum a[k]*y[n-k], with Q2.14
// coefficients set over the APB port (b0, b1, b2, a1, a2 at byte addresses 0 to 16;
// b0 resets to 1.0, the rest to zero; the feedback products are added). The input and
// output histories live in a row of tap cells, one per tap; after a sample transfer
// the partial sum walks down the row one cell per cycle, then is rounded half up,
// clamped to the sample range (saturated set when clamped) and placed in the output
// register. One sample is in flight at a time: a sample transfer launches the row through
// the go1 and go2 registers, the partial sum then passes each cell in turn, and the
// output register is loaded before the earliest next sample transfer.
// The next sample is taken while a result still waits in the output register; a
// result that cannot leave holds the row.
module iir_direct_form_one #(
  parameter int FF_TAPS     = iirdf1_pkg::FF_TAPS_DEF,
  parameter int FB_TAPS     = iirdf1_pkg::FB_TAPS_DEF,
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  iirdf1_in_if.sink                         in_ch,
  iirdf1_out_if.source                      out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [iirdf1_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [iirdf1_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import iirdf1_pkg::*;

  localparam int N_CELLS = FF_TAPS + FB_TAPS;
  localparam int ACC_W   = COEF_BITS + SAMPLE_BITS + 3;

  coef_bank_t coef_bank;

  logic [SAMPLE_BITS-1:0]  hist [N_CELLS];
  logic                    tok  [N_CELLS];
  logic signed [ACC_W-1:0] psum [N_CELLS];

  logic                   in_xfer;
  logic                   y_load;
  logic [SAMPLE_BITS-1:0] y_sat;
  logic                   sat;

  logic busy_r, busy_nxt;
  logic go1_r, go2_r;
  logic pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [SAMPLE_BITS-1:0] y_r;
  logic                   sat_r;

  iirdf1_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .coefs   (coef_bank)
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    logic [SAMPLE_BITS-1:0]        sh_in;
    logic                          sh_en;
    logic signed [COEF_BITS-1:0]   coef;
    logic                          tok_i;
    logic signed [ACC_W-1:0]       ps_i;

    if (k == 0) begin : g_head
      assign sh_in = in_ch.sample_in;
      assign tok_i = go2_r;
      assign ps_i  = '0;
    end else begin : g_link
      if (k == FF_TAPS) begin : g_fb_head
        assign sh_in = y_sat;
      end else begin : g_pass
        assign sh_in = hist[k-1];
      end
      assign tok_i = tok[k-1];
      assign ps_i  = psum[k-1];
    end

    if (k < FF_TAPS) begin : g_ff
      assign sh_en = in_xfer;
      assign coef  = $signed(coef_bank[k]);
    end else begin : g_fb
      assign sh_en = y_load;
      assign coef  = $signed(coef_bank[int'(REG_A1) + k - FF_TAPS]);
    end

    iirdf1_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
    ) u_tap (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (sh_en),
      .shift_in (sh_in),
      .coef     (coef),
      .tok_in   (tok_i),
      .psum_in  (ps_i),
      .sample_q (hist[k]),
      .tok_out  (tok[k]),
      .psum_out (psum[k])
    );
  end

  iirdf1_round_sat #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_round (
    .acc (psum[N_CELLS-1]),
    .y   (y_sat),
    .sat (sat)
  );

  always_comb begin
    in_xfer     = in_ch.valid & ~busy_r;
    // The last cell's sum holds until the output register is free
    y_load      = (tok[N_CELLS-1] | pend_r) & (~out_vld_r | out_ch.ready);
    pend_nxt    = (tok[N_CELLS-1] | pend_r) & ~y_load;
    busy_nxt    = (busy_r | in_xfer) & ~y_load;
    out_vld_nxt = y_load | (out_vld_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      go1_r     <= 1'b0;
      go2_r     <= 1'b0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      go1_r     <= in_xfer;
      go2_r     <= go1_r;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (y_load) begin
      y_r   <= y_sat;
      sat_r <= sat;
    end
  end

  assign in_ch.ready         = ~busy_r;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.filtered_out = y_r;
  assign out_ch.saturated    = sat_r;

endmodule

`default_nettype wire

>>> sim/tb_iir_direct_form_one.sv
// Self-checking testbench for the direct form I IIR filter: table of directed steps, then random phases.
`timescale 1ns / 1ps
`default_nettype none

module tb_iir_direct_form_one;
  import iirdf1_pkg::*;

  localparam int        HOLD_CYCLES = 80;
  localparam int        STALL_LIMIT = 2000;
  localparam int        DRAIN_TAIL  = FF_TAPS_DEF + FB_TAPS_DEF + 6;
  localparam int        PHASES      = 8;
  localparam int        PHASE_ITEMS = 100;
  localparam logic [2:0] REG_NONE   = 3'd5;   // no register behind this index

  typedef enum logic [0:0] {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum logic [1:0] {STYLE_FULL, STYLE_GENTLE, STYLE_MAX, STYLE_MIN} coef_style_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_sel;
    logic [31:0] data;     // register value, or the sample in bits 15:0
    logic        known;    // y and sat hold the expected result
    logic [15:0] y;
    logic        sat;
  } step_row_t;

  typedef struct {
    logic [15:0] y;
    logic        sat;
  } filt_result_t;

  localparam int DIRECTED_LEN = 32;
  localparam step_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // unity gain after reset
    '{ROW_SAMPLE, REG_B0, 32'h0000_0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_FFFF, 1'b1, 16'hFFFF, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_8000, 1'b1, 16'h8000, 1'b0},
    // gain 0.5, upper bus bits must be dropped; halves round up
    '{ROW_WRITE,  REG_B0, 32'hDEAD_2000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_FFFF, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0003, 1'b1, 16'h0002, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_FFFD, 1'b1, 16'hFFFF, 1'b0},
    // gain near 2.0 clips both ways
    '{ROW_WRITE,  REG_B0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_SAMPLE, REG_B0, 32'h0000_8000, 1'b1, 16'h8000, 1'b1},
    '{ROW_SAMPLE, REG_B0, 32'h0000_3FFF, 1'b0, 16'h0000, 1'b0},
    // full biquad with feedback; clipped outputs go back into the history
    '{ROW_WRITE,  REG_B1, 32'hFFFF_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_B2, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_A1, 32'h0000_4000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_A2, 32'h1234_C000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_NONE, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_3039, 1'b0, 16'h0000, 1'b0},
    // every coefficient at its most negative
    '{ROW_WRITE,  REG_B0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_B2, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_A1, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_WRITE,  REG_A2, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_0001, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, REG_B0, 32'h0000_FFFF, 1'b0, 16'h0000, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  iirdf1_in_if  in_bus ();
  iirdf1_out_if out_bus ();

  iir_direct_form_one DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Filter state as the block should hold it
  logic signed [15:0] coef   [NUM_REGS];
  logic signed [15:0] x_line [3];
  logic signed [15:0] y_line [2];

  filt_result_t pending_out [$];
  int           faults;
  int           idle_odds;   // percent chance to start an idle burst per sample, or a stall burst per cycle
  logic         steady;
  int           hold_req;
  int           quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic filt_result_t filter_step(input logic signed [15:0] x);
    filt_result_t res;
    longint       acc;
    longint       r;
    x_line[2] = x_line[1];
    x_line[1] = x_line[0];
    x_line[0] = x;
    acc = longint'(coef[REG_B0]) * longint'(x_line[0])
        + longint'(coef[REG_B1]) * longint'(x_line[1])
        + longint'(coef[REG_B2]) * longint'(x_line[2])
        + longint'(coef[REG_A1]) * longint'(y_line[0])
        + longint'(coef[REG_A2]) * longint'(y_line[1]);
    r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.sat = 1'b1;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    else res.sat = 1'b0;
    res.y = r[15:0];
    y_line[1] = y_line[0];
    y_line[0] = res.y;
    return res;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t ERROR %s", $realtime, msg);
  endtask

  // All tasks below start and end at a falling edge.
  task automatic write_reg(input logic [2:0] sel, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel <= REG_A2) coef[sel] = data[15:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_sample(input logic [15:0] x, input logic known,
                             input logic [15:0] y, input logic sat);
    filt_result_t res;
    if (!steady && $urandom_range(0, 99) < idle_odds) begin
      in_bus.valid     <= 1'b0;
      in_bus.sample_in <= 16'($urandom());
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    do @(posedge clk); while (!in_bus.ready);
    res = filter_step(x);
    if (known) begin
      res.y   = y;
      res.sat = sat;
    end
    pending_out.push_back(res);
    @(negedge clk);
  endtask

  task automatic drain;
    in_bus.valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coef(input coef_style_t style, input logic [2:0] sel);
    int v;
    case (style)
      STYLE_MAX: return {16'($urandom()), 16'h7FFF};
      STYLE_MIN: return {16'($urandom()), 16'h8000};
      STYLE_GENTLE: begin
        // keep feedback weak so outputs mostly stay inside the range
        if (sel >= REG_A1) v = int'($urandom_range(0, 12000)) - 6000;
        else v = int'($urandom_range(0, 24000)) - 12000;
        return {16'($urandom()), 16'(v)};
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      6, 7: return 16'(int'($urandom_range(0, 127)) - 64);
      8: return 16'h7FFF;
      9: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Result side: random stall bursts, plus a long hold when requested
  always @(negedge clk) begin : result_ready
    static int hold_seen  = 0;
    static int hold_left  = 0;
    static int stall_left = 0;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < idle_odds) begin
      stall_left = $urandom_range(0, 4);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    filt_result_t exp_res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_out.size() == 0) begin
        log_fault($sformatf("unexpected result y=%h sat=%b",
                            out_bus.filtered_out, out_bus.saturated));
      end else begin
        exp_res = pending_out.pop_front();
        if (out_bus.filtered_out !== exp_res.y || out_bus.saturated !== exp_res.sat)
          log_fault($sformatf("result mismatch: expected y=%h sat=%b, got y=%h sat=%b",
                              exp_res.y, exp_res.sat, out_bus.filtered_out,
                              out_bus.saturated));
      end
    end
  end

  // Watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL iir_direct_form_one");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    coef_style_t style;
    step_row_t   row;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    faults           = 0;
    idle_odds        = 25;
    steady           = 1'b0;
    hold_req         = 0;
    quiet_cycles     = 0;
    coef[REG_B0]     = COEF_B0_RST;
    coef[REG_B1]     = '0;
    coef[REG_B2]     = '0;
    coef[REG_A1]     = '0;
    coef[REG_A2]     = '0;
    foreach (x_line[i]) x_line[i] = '0;
    foreach (y_line[i]) y_line[i] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.reg_sel, row.data);
      end else begin
        push_sample(row.data[15:0], row.known, row.y, row.sat);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      style = coef_style_t'(p % 4);
      drain();
      for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), pick_coef(style, 3'(r)));
      if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(REG_NONE, 7)), $urandom());
      idle_odds = (p == 0) ? 0 : 10 + 10 * (p % 3);
      steady    = (p == PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 10) hold_req++;
        push_sample(pick_sample(), 1'b0, '0, 1'b0);
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (pending_out.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_out.size()));
    if (faults == 0) begin
      $display("PASS iir_direct_form_one");
    end else begin
      $display("FAIL iir_direct_form_one");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/iirdf1_pkg.sv
rtl/core/iirdf1_if.sv
rtl/core/iirdf1_tap_cell.sv
rtl/core/iirdf1_round_sat.sv
rtl/core/iirdf1_cfg_regs.sv
rtl/core/iir_direct_form_one.sv
sim/tb_iir_direct_form_one.sv
